// ===== rtl/core/positional_pid_regulator_top_defines.svh =====
// Assertion macros for the positional PID regulator.
// Included by positional_pid_regulator_top.sv; no other dependencies.
`ifndef POSITIONAL_PID_REGULATOR_TOP_DEFINES_SVH
`define POSITIONAL_PID_REGULATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_pid_regulator: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_pid_regulator: next-cycle check failed");

`endif

// ===== rtl/core/ppr_pkg.sv =====
// Shared widths, reset values, limits and register codes of the positional
// PID regulator. No dependencies.
`default_nettype none

package ppr_pkg;

  localparam int AngleW   = 16;
  localparam int GainW    = 16;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;
  localparam int ErrW     = AngleW + 1;
  localparam int SumW     = 13;
  localparam int SumFullW = ErrW + 1;
  localparam int DerivW   = ErrW + 1;
  localparam int ProdPW   = GainW + ErrW;
  localparam int ProdIW   = GainW + SumW;
  localparam int ProdDW   = GainW + DerivW;
  localparam int AccW     = ProdDW + 2;
  localparam int FracBits = 8;
  localparam int DriveW   = 9;
  localparam int ClampW   = DriveW + FracBits;

  localparam int IntLimit = 4000;
  localparam int OutLimit = 200;
  localparam int AccLimit = OutLimit * (1 << FracBits);

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET = 2'd0,
    REG_GAIN_P = 2'd1,
    REG_GAIN_I = 2'd2,
    REG_GAIN_D = 2'd3
  } cfg_reg_t;

  localparam logic signed [AngleW-1:0] TARGET_RST = 16'sd0;
  localparam logic signed [GainW-1:0]  GAIN_P_RST = 16'sd5120;
  localparam logic signed [GainW-1:0]  GAIN_I_RST = 16'sd0;
  localparam logic signed [GainW-1:0]  GAIN_D_RST = 16'sd512;

endpackage

`default_nettype wire

// ===== rtl/core/positional_pid_regulator_top.sv =====
// Positional PID regulator: error, clamped integral, derivative, Q8 sum.
// Depends on ppr_pkg.sv and positional_pid_regulator_top_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready/in_measured_angle) takes one measured
//   angle per request. Output channel (out_valid/out_ready/out_drive_value)
//   returns exactly one drive value per request, in request order.
//   Configuration port (cfg_wr_en/cfg_index/cfg_data) writes the setpoint and
//   the three Q8.8 gains; write only while no request is in flight.
//   Pipeline: an accepted request loads the error/integral stage, then the
//   multiply stage, then the sum-and-clamp output register behind out_valid.
//   Throughput: one request per cycle unless the output stalls. Integral and
//   previous error update in the first stage; consecutive requests need no waiting.
//   Stall: when out_valid is high and out_ready is low the output register holds
//   its value; the two inner stages keep filling, and in_ready drops once all
//   three stages hold a request.
//   Reset (rst_n low, synchronous): pipeline emptied, integral and previous
//   error cleared, setpoint 0, gains 20.0 / 0.0 / 2.0.
`default_nettype none

`include "positional_pid_regulator_top_defines.svh"

module positional_pid_regulator_top (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire  signed [ppr_pkg::AngleW-1:0]        in_measured_angle,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic signed [ppr_pkg::DriveW-1:0]        out_drive_value,
  input  wire                                      cfg_wr_en,
  input  wire         [ppr_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire         [ppr_pkg::CfgDataW-1:0]      cfg_data
);

  localparam int ErrW     = ppr_pkg::ErrW;
  localparam int SumW     = ppr_pkg::SumW;
  localparam int SumFullW = ppr_pkg::SumFullW;
  localparam int DerivW   = ppr_pkg::DerivW;
  localparam int AccW     = ppr_pkg::AccW;
  localparam int ClampW   = ppr_pkg::ClampW;
  localparam int FracBits = ppr_pkg::FracBits;
  localparam int DriveW   = ppr_pkg::DriveW;

  localparam logic signed [SumFullW-1:0] SumHi = SumFullW'(ppr_pkg::IntLimit);
  localparam logic signed [SumFullW-1:0] SumLo = -SumFullW'(ppr_pkg::IntLimit);
  localparam logic signed [AccW-1:0]     AccHi = AccW'(ppr_pkg::AccLimit);
  localparam logic signed [AccW-1:0]     AccLo = -AccW'(ppr_pkg::AccLimit);
  localparam logic signed [SumW-1:0]     IntHi = SumW'(ppr_pkg::IntLimit);
  localparam logic signed [SumW-1:0]     IntLo = -SumW'(ppr_pkg::IntLimit);
  localparam logic signed [DriveW-1:0]   DrvHi = DriveW'(ppr_pkg::OutLimit);
  localparam logic signed [DriveW-1:0]   DrvLo = -DriveW'(ppr_pkg::OutLimit);

  // Configuration registers.
  logic signed [ppr_pkg::AngleW-1:0] target_r;
  logic signed [ppr_pkg::GainW-1:0]  gain_p_r;
  logic signed [ppr_pkg::GainW-1:0]  gain_i_r;
  logic signed [ppr_pkg::GainW-1:0]  gain_d_r;

  // Controller state.
  logic signed [SumW-1:0] error_sum_r;
  logic signed [ErrW-1:0] prev_err_r;

  // Pipeline registers.
  logic                          s1_valid_r;
  logic signed [ErrW-1:0]        s1_err_r;
  logic signed [SumW-1:0]        s1_sum_r;
  logic signed [DerivW-1:0]      s1_deriv_r;
  logic                          s2_valid_r;
  logic signed [ppr_pkg::ProdPW-1:0] s2_prod_p_r;
  logic signed [ppr_pkg::ProdIW-1:0] s2_prod_i_r;
  logic signed [ppr_pkg::ProdDW-1:0] s2_prod_d_r;
  logic                          out_valid_r;
  logic signed [DriveW-1:0]      out_drive_r;

  logic s1_en, s2_en, s3_en, in_fire;

  logic signed [ErrW-1:0]     err_nxt;
  logic signed [SumFullW-1:0] sum_full;
  logic signed [SumW-1:0]     sum_nxt;
  logic signed [DerivW-1:0]   deriv_nxt;
  logic signed [AccW-1:0]     acc;
  logic signed [ClampW-1:0]   acc_clamped;
  logic signed [DriveW-1:0]   drive_nxt;

  assign s3_en    = !out_valid_r || out_ready;
  assign s2_en    = !s2_valid_r || s3_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;
  assign in_fire  = in_valid && s1_en;

  assign out_valid       = out_valid_r;
  assign out_drive_value = out_drive_r;

  // Stage 1: error, clamped integral and derivative.
  always_comb begin
    err_nxt   = {target_r[ppr_pkg::AngleW-1], target_r}
              - {in_measured_angle[ppr_pkg::AngleW-1], in_measured_angle};
    sum_full  = {{(SumFullW-SumW){error_sum_r[SumW-1]}}, error_sum_r}
              + {err_nxt[ErrW-1], err_nxt};
    if (sum_full > SumHi) begin
      sum_nxt = IntHi;
    end else if (sum_full < SumLo) begin
      sum_nxt = IntLo;
    end else begin
      sum_nxt = sum_full[SumW-1:0];
    end
    deriv_nxt = {err_nxt[ErrW-1], err_nxt} - {prev_err_r[ErrW-1], prev_err_r};
  end

  // Stage 3: Q8 sum, clamp, then divide by 256 toward zero.
  always_comb begin
    acc = AccW'(s2_prod_p_r) + AccW'(s2_prod_i_r) + AccW'(s2_prod_d_r);
    if (acc > AccHi) begin
      acc_clamped = AccHi[ClampW-1:0];
    end else if (acc < AccLo) begin
      acc_clamped = AccLo[ClampW-1:0];
    end else begin
      acc_clamped = acc[ClampW-1:0];
    end
    // The arithmetic shift floors; a negative value with a fraction moves up by one.
    drive_nxt = acc_clamped[ClampW-1:FracBits];
    if (acc_clamped[ClampW-1] && (|acc_clamped[FracBits-1:0])) begin
      drive_nxt = drive_nxt + DriveW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= ppr_pkg::TARGET_RST;
      gain_p_r <= ppr_pkg::GAIN_P_RST;
      gain_i_r <= ppr_pkg::GAIN_I_RST;
      gain_d_r <= ppr_pkg::GAIN_D_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ppr_pkg::REG_TARGET: target_r <= cfg_data;
        ppr_pkg::REG_GAIN_P: gain_p_r <= cfg_data;
        ppr_pkg::REG_GAIN_I: gain_i_r <= cfg_data;
        ppr_pkg::REG_GAIN_D: gain_d_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      prev_err_r  <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        error_sum_r <= sum_nxt;
        prev_err_r  <= err_nxt;
      end
      if (s1_en) begin
        s1_valid_r <= in_valid;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_en) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_err_r   <= err_nxt;
      s1_sum_r   <= sum_nxt;
      s1_deriv_r <= deriv_nxt;
    end
    if (s2_en && s1_valid_r) begin
      s2_prod_p_r <= ppr_pkg::ProdPW'(gain_p_r) * ppr_pkg::ProdPW'(s1_err_r);
      s2_prod_i_r <= ppr_pkg::ProdIW'(gain_i_r) * ppr_pkg::ProdIW'(s1_sum_r);
      s2_prod_d_r <= ppr_pkg::ProdDW'(gain_d_r) * ppr_pkg::ProdDW'(s1_deriv_r);
    end
    if (s3_en && s2_valid_r) begin
      out_drive_r <= drive_nxt;
    end
  end

  `PPR_ASSERT_SAME(a_integral_bounded, clk, rst_n, 1'b1, (error_sum_r <= IntHi) && (error_sum_r >= IntLo))
  `PPR_ASSERT_SAME(a_drive_bounded, clk, rst_n, out_valid_r, (out_drive_r <= DrvHi) && (out_drive_r >= DrvLo))
  `PPR_ASSERT_NEXT(a_prev_err_tracks, clk, rst_n, in_fire, s1_valid_r && (s1_err_r == prev_err_r))
  `PPR_ASSERT_NEXT(a_mid_stage_holds, clk, rst_n, s2_valid_r && !s3_en, s2_valid_r && $stable(s2_prod_p_r))

endmodule

`default_nettype wire
